// ===== design/ksvm_pkg.sv =====
// Shared types, constants and helpers for the kernel SVM classifier.
// No dependencies; imported by kernel_svm_classifier_unit and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package ksvm_pkg;

  localparam int NUM_VECTORS     = 64;
  localparam int NUM_FEATURES    = 16;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int VIDX_W = $clog2(NUM_VECTORS);
  localparam int FIDX_W = $clog2(NUM_FEATURES);
  localparam int VS_AW  = $clog2(NUM_VECTORS * NUM_FEATURES);
  localparam int EXP_AW = $clog2(EXP_TABLE_DEPTH);
  localparam int VCNT_W = VIDX_W + 1;
  // accumulator widths: worst case of the sums plus one sign bit
  localparam int DOT_W  = 33 + FIDX_W;
  localparam int DIST_W = 34 + FIDX_W;
  localparam int T_W    = 16 + DIST_W;
  localparam int ACC_W  = 40 + VIDX_W;

  localparam logic [63:0] EXP_STEP_RATIO = 64'd4034748382;

  typedef enum logic [1:0] {
    OP_LOAD_VEC  = 2'd0,
    OP_LOAD_COEF = 2'd1,
    OP_QUERY     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KM_LINEAR = 2'd0,
    KM_POLY   = 2'd1,
    KM_GAUSS  = 2'd2
  } kmode_e;

  typedef enum logic [2:0] {
    REG_KERNEL_MODE  = 3'd0,
    REG_POLY_DEGREE  = 3'd1,
    REG_POLY_OFFSET  = 3'd2,
    REG_RBF_GAMMA    = 3'd3,
    REG_SCORE_BIAS   = 3'd4,
    REG_VECTOR_COUNT = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_KSEL,
    ST_POLY_MUL,
    ST_POLY_SAT,
    ST_GAUSS_LUT,
    ST_TERM_MUL,
    ST_TERM_ACC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [5:0]         vector_index;
    logic [3:0]         feature_index;
    logic signed [15:0] feature_value;
    logic signed [23:0] coeff_value;
    logic               query_last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic               class_positive;
  } out_item_t;

  typedef logic [15:0] exp_tab_t [EXP_TABLE_DEPTH];

  // exp(-k/16) in Q0.16, built at elaboration
  function automatic exp_tab_t gen_exp_table();
    exp_tab_t    t;
    logic [63:0] v;
    logic [63:0] e;
    v = 64'hFFFF_FFFF;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      if (k > 0) begin
        v = (v * EXP_STEP_RATIO) >> 32;
      end
      e = (v + 64'd32768) >> 16;
      t[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TABLE = gen_exp_table();

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/ksvm_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ksvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/kernel_svm_classifier_unit.sv =====
// Top level of the kernel SVM classifier: sequencer, datapath, stores.
// Depends on ksvm_pkg and ksvm_ram.
//
// Use: in_item_i carries load and query items (valid/stall). Loads of a
// support-vector feature or a coefficient, and a query feature without
// query_last, are taken while idle. A query item with query_last starts
// scoring; one result item then appears on out_item_o (valid/stall).
// Scoring walks the active vectors one by one. For each vector the feature
// store is streamed, one feature a cycle through a three-stage
// multiply/accumulate, then the kernel is formed (linear: dot product;
// polynomial: a multiply and a saturate per degree; gaussian: a product
// and a table lookup) and the coefficient term is multiplied and added.
// The single read port of the feature store sets the feature rate. Stores
// are touched by loads only in idle, by the scorer only when busy, so no
// forwarding is needed. in_stall_o is high while a query is scored. A
// finished result waits in the output register while new items are taken;
// a later result waits for it to be taken. Reset clears control state and
// loads register defaults; store contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module kernel_svm_classifier_unit
  import ksvm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire in_item_t  in_item_i,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_item_t out_item_o,
  input  wire logic      cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i
);

  // configuration registers
  logic [1:0]         kernel_mode_q;
  logic [3:0]         poly_degree_q;
  logic signed [15:0] poly_offset_q;
  logic [15:0]        rbf_gamma_q;
  logic signed [31:0] score_bias_q;
  logic [6:0]         vector_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_mode_q  <= 2'd0;
      poly_degree_q  <= 4'd2;
      poly_offset_q  <= '0;
      rbf_gamma_q    <= 16'd256;
      score_bias_q   <= '0;
      vector_count_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_KERNEL_MODE:  kernel_mode_q  <= cfg_wdata_i[1:0];
        REG_POLY_DEGREE:  poly_degree_q  <= cfg_wdata_i[3:0];
        REG_POLY_OFFSET:  poly_offset_q  <= cfg_wdata_i[15:0];
        REG_RBF_GAMMA:    rbf_gamma_q    <= cfg_wdata_i[15:0];
        REG_SCORE_BIAS:   score_bias_q   <= cfg_wdata_i;
        REG_VECTOR_COUNT: vector_count_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic in_acc;
  logic is_load_vec, is_load_coef, is_query, start_score;
  assign in_acc       = in_valid_i && !in_stall_o;
  assign is_load_vec  = in_acc && (in_item_i.operation == OP_LOAD_VEC)
                        && (int'(in_item_i.vector_index) < NUM_VECTORS)
                        && (int'(in_item_i.feature_index) < NUM_FEATURES);
  assign is_load_coef = in_acc && (in_item_i.operation == OP_LOAD_COEF)
                        && (int'(in_item_i.vector_index) < NUM_VECTORS);
  assign is_query     = in_acc && (in_item_i.operation == OP_QUERY);
  assign start_score  = is_query && in_item_i.query_last;

  // vector walk counters
  logic [VIDX_W-1:0] v_q, last_v_q;
  logic [FIDX_W-1:0] f_q, last_f_q;
  logic [3:0]        deg_cnt_q;

  // query buffer: one write port, read only at f_q
  logic signed [15:0] qbuf_q [NUM_FEATURES];

  always_ff @(posedge clk_i) begin
    if (is_query && (int'(in_item_i.feature_index) < NUM_FEATURES)) begin
      qbuf_q[in_item_i.feature_index[FIDX_W-1:0]] <= in_item_i.feature_value;
    end
  end

  // stores
  logic signed [15:0] vs_rdata;
  logic signed [23:0] coef_rdata;
  logic [VS_AW-1:0]   vs_waddr;

  assign vs_waddr = {in_item_i.vector_index[VIDX_W-1:0],
                     in_item_i.feature_index[FIDX_W-1:0]};

  ksvm_ram #(.WIDTH(16), .DEPTH(NUM_VECTORS * NUM_FEATURES)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (is_load_vec),
    .waddr_i (vs_waddr),
    .wdata_i (in_item_i.feature_value),
    .raddr_i ({v_q, f_q}),
    .rdata_o (vs_rdata)
  );

  ksvm_ram #(.WIDTH(24), .DEPTH(NUM_VECTORS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (is_load_coef),
    .waddr_i (in_item_i.vector_index[VIDX_W-1:0]),
    .wdata_i (in_item_i.coeff_value),
    .raddr_i (v_q),
    .rdata_o (coef_rdata)
  );

  // vector count clamp; zero means bias only
  logic              vc_zero;
  logic [VIDX_W-1:0] vc_last;
  always_comb begin
    vc_zero = (vector_count_q == '0);
    if (int'(vector_count_q) > NUM_VECTORS) begin
      vc_last = VIDX_W'(NUM_VECTORS - 1);
    end else begin
      vc_last = VIDX_W'(vector_count_q - 7'd1);
    end
  end

  // next state
  logic acc_done_q;
  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_score) begin
          state_d = vc_zero ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN:  if (f_q == last_f_q) state_d = ST_WAIT;
      ST_WAIT: if (acc_done_q) state_d = ST_KSEL;
      ST_KSEL: begin
        case (kmode_e'(kernel_mode_q))
          KM_POLY:  state_d = (poly_degree_q == '0) ? ST_TERM_MUL : ST_POLY_MUL;
          KM_GAUSS: state_d = ST_GAUSS_LUT;
          default:  state_d = ST_TERM_MUL;
        endcase
      end
      ST_POLY_MUL:  state_d = ST_POLY_SAT;
      ST_POLY_SAT:  state_d = (deg_cnt_q == 4'd1) ? ST_TERM_MUL : ST_POLY_MUL;
      ST_GAUSS_LUT: state_d = ST_TERM_MUL;
      ST_TERM_MUL:  state_d = ST_TERM_ACC;
      ST_TERM_ACC:  state_d = (v_q == last_v_q) ? ST_FINISH : ST_RUN;
      ST_FINISH:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // feature stream pipeline: read -> product -> accumulate
  logic               s1_valid_q, s1_end_q;
  logic signed [15:0] s1_q_q;
  logic               s2_valid_q, s2_end_q;
  logic signed [31:0] s2_prod_q;
  logic [33:0]        s2_sq_q;
  logic signed [16:0] diff;

  assign diff = 17'(vs_rdata) - 17'(s1_q_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_end_q   <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_end_q   <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      s1_valid_q <= (state_q == ST_RUN);
      s1_end_q   <= (state_q == ST_RUN) && (f_q == last_f_q);
      s2_valid_q <= s1_valid_q;
      s2_end_q   <= s1_end_q;
      acc_done_q <= s2_end_q;
    end
  end

  logic signed [DOT_W-1:0]  dot_q;
  logic [DIST_W-1:0]        dist_q;
  logic signed [31:0]       base_q, kval_q;
  logic signed [63:0]       pm_q;
  logic [T_W-1:0]           t_q;
  logic signed [55:0]       tm_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [63:0]       final_sum;
  logic signed [31:0]       score_sat;
  logic                     out_valid_q;
  out_item_t                out_item_q;

  assign final_sum = 64'(acc_q) + 64'(score_bias_q);
  assign score_sat = sat32(final_sum);

  // datapath
  always_ff @(posedge clk_i) begin
    s1_q_q    <= qbuf_q[f_q];
    s2_prod_q <= vs_rdata * s1_q_q;
    s2_sq_q   <= 34'(diff * diff);
    if (s2_valid_q) begin
      dot_q  <= dot_q + DOT_W'(s2_prod_q);
      dist_q <= dist_q + DIST_W'(s2_sq_q);
    end
    case (state_q)
      ST_IDLE: begin
        if (start_score) begin
          if (int'(in_item_i.feature_index) < NUM_FEATURES) begin
            last_f_q <= in_item_i.feature_index[FIDX_W-1:0];
          end else begin
            last_f_q <= FIDX_W'(NUM_FEATURES - 1);
          end
          last_v_q <= vc_last;
          v_q      <= '0;
          f_q      <= '0;
          dot_q    <= '0;
          dist_q   <= '0;
          acc_q    <= '0;
        end
      end
      ST_RUN: f_q <= f_q + 1'b1;
      ST_KSEL: begin
        case (kmode_e'(kernel_mode_q))
          KM_LINEAR: kval_q <= sat32(64'(dot_q));
          KM_POLY: begin
            base_q    <= sat32(64'(dot_q) + (64'(poly_offset_q) <<< 8));
            kval_q    <= 32'sd65536;
            deg_cnt_q <= poly_degree_q;
          end
          KM_GAUSS: t_q <= T_W'(rbf_gamma_q * dist_q);
          default:  kval_q <= '0;
        endcase
      end
      ST_POLY_MUL: pm_q <= kval_q * base_q;
      ST_POLY_SAT: begin
        kval_q    <= sat32(pm_q >>> 16);
        deg_cnt_q <= deg_cnt_q - 4'd1;
      end
      ST_GAUSS_LUT: begin
        if (t_q[T_W-1:20+EXP_AW] == '0) begin
          kval_q <= {16'd0, EXP_TABLE[t_q[20+EXP_AW-1:20]]};
        end else begin
          kval_q <= '0;
        end
      end
      ST_TERM_MUL: tm_q <= coef_rdata * kval_q;
      ST_TERM_ACC: begin
        acc_q  <= acc_q + ACC_W'(tm_q >>> 16);
        v_q    <= v_q + 1'b1;
        f_q    <= '0;
        dot_q  <= '0;
        dist_q <= '0;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_item_q.score          <= score_sat;
          out_item_q.class_positive <= !score_sat[31];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside finish");

  a_stream_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (state_q == ST_RUN || state_q == ST_WAIT))
    else $error("feature stream active outside vector walk");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done_q |-> state_q == ST_WAIT)
    else $error("accumulate done outside wait");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(out_item_q))
    else $error("stalled result lost or changed");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for kernel_svm_classifier_unit: loads, queries, kernel modes.
// Depends on ksvm_pkg and the RTL of the block; predicts each score in the bench itself.
`timescale 1ns / 1ps
module testbench;
  import ksvm_pkg::*;

  localparam op_e OP_UNUSED = op_e'(2'b11);
  localparam longint unsigned EXP_RATIO = 64'd4034748382;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  kernel_svm_classifier_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror of the block's registers and stores
  logic [1:0]         m_kmode;
  logic [3:0]         m_degree;
  logic signed [15:0] m_offset;
  logic [15:0]        m_gamma;
  logic signed [31:0] m_bias;
  logic [6:0]         m_vcount;
  logic signed [15:0] sv_mem [NUM_VECTORS][NUM_FEATURES];
  logic signed [23:0] coef_mem [NUM_VECTORS];
  logic signed [15:0] qbuf [NUM_FEATURES];
  bit                 sv_written [NUM_VECTORS][NUM_FEATURES];
  bit                 coef_written [NUM_VECTORS];
  bit                 q_written [NUM_FEATURES];
  logic [15:0]        exp_lut [EXP_TABLE_DEPTH];

  out_item_t expected_scores [$];
  int        errors = 0;
  int        n_sent = 0;
  int        snd_idle = 0;
  int        rcv_idle = 0;
  bit        hold_trig = 1'b0;
  bit        hold_seen = 1'b0;
  int        hold_left = 0;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // exp(-k/16) in Q0.16 by the stepwise ratio
  function automatic void build_exp_lut();
    longint unsigned v;
    longint unsigned e;
    v = 64'hFFFF_FFFF;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      if (k > 0) v = (v * EXP_RATIO) >> 32;
      e = (v + 64'd32768) >> 16;
      exp_lut[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
    end
  endfunction

  function automatic out_item_t score_query(int d);
    out_item_t       res;
    longint          acc, dot, sq_dist, a, b, kv, base, r;
    longint unsigned t;
    int              n;
    acc = 0;
    n = (m_vcount > NUM_VECTORS) ? NUM_VECTORS : int'(m_vcount);
    for (int v = 0; v < n; v++) begin
      dot = 0;
      sq_dist = 0;
      for (int f = 0; f < d; f++) begin
        a = sv_mem[v][f];
        b = qbuf[f];
        dot += a * b;
        sq_dist += (a - b) * (a - b);
      end
      case (m_kmode)
        KM_LINEAR: kv = clamp32(dot);
        KM_POLY: begin
          base = clamp32(dot + longint'(m_offset) * 256);
          r = 65536;
          for (int i = 0; i < m_degree; i++) r = clamp32((r * base) >>> 16);
          kv = r;
        end
        KM_GAUSS: begin
          t = longint'(m_gamma) * sq_dist;
          kv = ((t >> 20) < EXP_TABLE_DEPTH) ? longint'(exp_lut[t >> 20]) : 0;
        end
        default: kv = 0;
      endcase
      acc += (longint'(coef_mem[v]) * kv) >>> 16;
    end
    acc = clamp32(acc + longint'(m_bias));
    res.score = acc[31:0];
    res.class_positive = (acc >= 0);
    return res;
  endfunction

  // model update for an item the block has taken
  function automatic void absorb_item(in_item_t it);
    case (it.operation)
      OP_LOAD_VEC: begin
        sv_mem[it.vector_index][it.feature_index] = it.feature_value;
        sv_written[it.vector_index][it.feature_index] = 1'b1;
      end
      OP_LOAD_COEF: begin
        coef_mem[it.vector_index] = it.coeff_value;
        coef_written[it.vector_index] = 1'b1;
      end
      OP_QUERY: begin
        qbuf[it.feature_index] = it.feature_value;
        q_written[it.feature_index] = 1'b1;
        if (it.query_last) expected_scores.push_back(score_query(it.feature_index + 1));
      end
      default: ;
    endcase
  endfunction

  // receiver: random stall plus the long hold-off on request
  always @(posedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_scores.size() == 0) begin
        $error("unexpected result item, score %0d", $signed(out_item.score));
        errors++;
      end else begin
        if (out_item.score !== expected_scores[0].score) begin
          $error("score expected %0d actual %0d",
                 $signed(expected_scores[0].score), $signed(out_item.score));
          errors++;
        end
        if (out_item.class_positive !== expected_scores[0].class_positive) begin
          $error("class_positive expected %0b actual %0b",
                 expected_scores[0].class_positive, out_item.class_positive);
          errors++;
        end
        void'(expected_scores.pop_front());
      end
    end
  end

  task automatic send_item(in_item_t it);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    n_sent++;
    absorb_item(it);
  endtask

  // wait for every score, then let trailing loads settle
  task automatic drain();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_KERNEL_MODE:  m_kmode = val[1:0];
      REG_POLY_DEGREE:  m_degree = val[3:0];
      REG_POLY_OFFSET:  m_offset = val[15:0];
      REG_RBF_GAMMA:    m_gamma = val[15:0];
      REG_SCORE_BIAS:   m_bias = val;
      REG_VECTOR_COUNT: m_vcount = val[6:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_feature();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(1023)) - 512);
      3: return 16'(int'($urandom_range(255)) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_coef();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(int'($urandom_range(131071)) - 65536);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic load_feature(int v, int f, logic [15:0] val);
    in_item_t it;
    it = in_item_t'($urandom);
    it.operation = OP_LOAD_VEC;
    it.vector_index = 6'(v);
    it.feature_index = 4'(f);
    it.feature_value = val;
    send_item(it);
  endtask

  task automatic load_coef(int v, logic [23:0] val);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.operation = OP_LOAD_COEF;
    it.vector_index = 6'(v);
    it.coeff_value = val;
    send_item(it);
  endtask

  // fill any store entry that a query of length d would read
  task automatic fill_missing(int d);
    int n;
    n = (m_vcount > NUM_VECTORS) ? NUM_VECTORS : int'(m_vcount);
    for (int v = 0; v < n; v++) begin
      for (int f = 0; f < d; f++)
        if (!sv_written[v][f]) load_feature(v, f, rand_feature());
      if (!coef_written[v]) load_coef(v, rand_coef());
    end
  endtask

  // features below d - 1 go out in shuffled order, some skipped if already held; feature d - 1 goes last
  task automatic run_query(int d);
    in_item_t it;
    int       order [$];
    fill_missing(d);
    for (int f = 0; f < d - 1; f++)
      if (!q_written[f] || $urandom_range(3) != 0) order.push_back(f);
    order.shuffle();
    foreach (order[i]) begin
      it = in_item_t'({$urandom, $urandom});
      it.operation = OP_QUERY;
      it.feature_index = 4'(order[i]);
      it.feature_value = rand_feature();
      it.query_last = 1'b0;
      send_item(it);
    end
    it = in_item_t'({$urandom, $urandom});
    it.operation = OP_QUERY;
    it.feature_index = 4'(d - 1);
    it.feature_value = rand_feature();
    it.query_last = 1'b1;
    send_item(it);
  endtask

  function automatic int pick_length();
    if (m_vcount > 16) return $urandom_range(1, 2);
    return $urandom_range(1, NUM_FEATURES);
  endfunction

  // extremes of features, coefficients and bias under the linear kernel
  task automatic test_linear_extremes();
    cfg_write(REG_VECTOR_COUNT, 32'd2);
    cfg_write(REG_KERNEL_MODE, KM_LINEAR);
    load_feature(0, 0, 16'h7FFF);
    load_feature(0, 1, 16'h8000);
    load_feature(1, 0, 16'h8000);
    load_feature(1, 1, 16'h8000);
    load_coef(0, 24'h7FFFFF);
    load_coef(1, 24'h800000);
    run_query(2);
    drain();
    cfg_write(REG_SCORE_BIAS, 32'h7FFF_FFFF);
    run_query(2);
    drain();
    cfg_write(REG_SCORE_BIAS, 32'h8000_0000);
    run_query(2);
    drain();
  endtask

  // polynomial at degree zero and eight, gaussian widths, unused mode
  task automatic test_kernels();
    cfg_write(REG_SCORE_BIAS, 32'd0);
    cfg_write(REG_KERNEL_MODE, KM_POLY);
    cfg_write(REG_POLY_DEGREE, 32'd0);
    cfg_write(REG_POLY_OFFSET, 32'h0000_7FFF);
    run_query(2);
    drain();
    cfg_write(REG_POLY_DEGREE, 32'd8);
    cfg_write(REG_POLY_OFFSET, 32'hFFFF_8000);
    run_query(1);
    drain();
    cfg_write(REG_KERNEL_MODE, KM_GAUSS);
    cfg_write(REG_RBF_GAMMA, 32'd0);
    run_query(2);
    drain();
    cfg_write(REG_RBF_GAMMA, 32'hFFFF);
    run_query(1);
    drain();
    cfg_write(REG_KERNEL_MODE, 32'd3); // unused mode: score is the bias
    cfg_write(REG_SCORE_BIAS, 32'hFFFF_FFFF);
    run_query(1);
    drain();
  endtask

  // no vectors, then a count beyond the store that saturates
  task automatic test_vector_count();
    in_item_t it;
    cfg_write(REG_KERNEL_MODE, KM_LINEAR);
    cfg_write(REG_VECTOR_COUNT, 32'd0);
    run_query(1);
    it = in_item_t'({$urandom, $urandom});
    it.operation = OP_UNUSED;
    it.query_last = 1'b1;
    send_item(it); // ignored item, no result
    drain();
    cfg_write(REG_VECTOR_COUNT, 32'd127);
    run_query(1);
    drain();
  endtask

  // result held off for long while queries keep coming
  task automatic test_backpressure();
    cfg_write(REG_VECTOR_COUNT, 32'd3);
    fill_missing(4);
    hold_trig <= ~hold_trig;
    repeat (4) run_query(4);
    drain();
  endtask

  task automatic random_config();
    cfg_write(REG_KERNEL_MODE, $urandom_range(3) == 3 ? 32'd3 : $urandom_range(2));
    cfg_write(REG_POLY_DEGREE, $urandom_range(8));
    cfg_write(REG_POLY_OFFSET, $urandom_range(1) ? 32'($urandom) : $urandom_range(512));
    cfg_write(REG_RBF_GAMMA, $urandom_range(1) ? $urandom_range(64) : 32'($urandom));
    cfg_write(REG_SCORE_BIAS, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20));
    case ($urandom_range(9))
      0: cfg_write(REG_VECTOR_COUNT, 32'd64);
      1: cfg_write(REG_VECTOR_COUNT, $urandom_range(127));
      default: cfg_write(REG_VECTOR_COUNT, $urandom_range(1, 8));
    endcase
  endtask

  task automatic test_random(int budget);
    in_item_t it;
    int       start;
    int       third;
    start = n_sent;
    third = budget / 3;
    while (n_sent - start < budget) begin
      if (n_sent - start < third) begin
        snd_idle = 38;
        rcv_idle = 45;
      end else if (n_sent - start < 2 * third) begin
        snd_idle = 45;
        rcv_idle = 38;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      drain();
      random_config();
      repeat ($urandom_range(3, 8)) begin
        case ($urandom_range(9))
          0: load_feature($urandom_range(63), $urandom_range(15), rand_feature());
          1: load_coef($urandom_range(63), rand_coef());
          2: begin
            it = in_item_t'({$urandom, $urandom});
            it.operation = OP_UNUSED;
            send_item(it);
          end
          default: run_query(pick_length());
        endcase
      end
    end
    // sender waits out every score before returning
    drain();
  endtask

  initial begin
    build_exp_lut();
    m_kmode = KM_LINEAR;
    m_degree = 4'd2;
    m_offset = '0;
    m_gamma = 16'd256;
    m_bias = '0;
    m_vcount = 7'd64;
    foreach (qbuf[f]) q_written[f] = 1'b0;
    foreach (coef_written[v]) coef_written[v] = 1'b0;
    foreach (sv_written[v, f]) sv_written[v][f] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);
    test_linear_extremes();
    test_kernels();
    test_vector_count();
    test_backpressure();
    test_random(1000);
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("kernel_svm_classifier_unit: match");
    end else begin
      $display("kernel_svm_classifier_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("kernel_svm_classifier_unit: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
design/ksvm_pkg.sv
design/ksvm_ram.sv
design/kernel_svm_classifier_unit.sv
dv/testbench.sv
